// ===== design/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

	// Default store size and fixed field widths.
	localparam int NUM_FRAMES_DEF = 4096;
	localparam int CMD_W          = 2;
	localparam int FRAME_W        = 12;
	localparam int STATUS_W       = 2;
	localparam int CFG_W          = 13;
	localparam int CFG_IDX_W      = 1;

	// One status row holds 32 frames, 2 bits each.
	localparam int ROW_LOG = 5;
	localparam int ROW_FRAMES = 32;
	localparam int ROW_BITS = 2 * ROW_FRAMES;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 1'b1;

	localparam logic [CFG_W-1:0] FRAME_LIMIT_RST = 13'd4096;

	// Commands.
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

	// Result codes.
	localparam logic [STATUS_W-1:0] RES_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] RES_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] RES_BAD   = 2'd2;

	// Per-frame status codes.
	localparam logic [1:0] FS_FREE = 2'b00;
	localparam logic [1:0] FS_USED = 2'b01;
	localparam logic [1:0] FS_HOLE = 2'b11;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_A_ROW0,
		ST_A_SCAN,
		ST_A_ROW,
		ST_UPD_ROW,
		ST_SUM_WR,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		ROW_FIRST,
		ROW_FRAME,
		ROW_SCAN
	} row_src_t;

	typedef enum logic [1:0] {
		SUM_START,
		SUM_NEXT,
		SUM_ROW
	} sum_src_t;

	typedef struct packed {
		logic                clr_en;
		logic                cap;
		logic                row_rd;
		row_src_t            row_src;
		logic                row_wr;
		logic                sum_rd;
		sum_src_t            sum_src;
		logic                sum_wr;
		logic                set_res;
		logic [STATUS_W-1:0] res_code;
		logic                load_out;
	} ctrl_t;

	typedef struct packed {
		logic             clr_done;
		logic [CMD_W-1:0] cmd;
		logic             win_empty;
		logic             f_in_win;
		logic             f_in_store;
		logic             row_hit;
		logic             f_used;
		logic             scan_hit;
		logic             scan_last;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/pfa_ram.sv =====
`default_nettype none

module pfa_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/pfa_ctrl.sv =====
`default_nettype none

module pfa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pfa_pkg::stat_t stat,
	output pfa_pkg::ctrl_t ctrl
);

	pfa_pkg::state_t state_q;
	pfa_pkg::state_t state_n;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfa_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pfa_pkg::ST_CLEAR: begin
				ctrl.clr_en = 1'b1;
				if (stat.clr_done) begin
					state_n = pfa_pkg::ST_IDLE;
				end
			end
			pfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.cap = 1'b1;
					state_n  = pfa_pkg::ST_DECODE;
				end
			end
			pfa_pkg::ST_DECODE: begin
				unique case (stat.cmd)
					pfa_pkg::CMD_ALLOC: begin
						if (stat.win_empty) begin
							ctrl.set_res  = 1'b1;
							ctrl.res_code = pfa_pkg::RES_EMPTY;
							state_n       = pfa_pkg::ST_RESP;
						end else begin
							ctrl.row_rd  = 1'b1;
							ctrl.row_src = pfa_pkg::ROW_FIRST;
							state_n      = pfa_pkg::ST_A_ROW0;
						end
					end
					pfa_pkg::CMD_FREE: begin
						if (stat.f_in_win) begin
							ctrl.row_rd  = 1'b1;
							ctrl.row_src = pfa_pkg::ROW_FRAME;
							state_n      = pfa_pkg::ST_UPD_ROW;
						end else begin
							ctrl.set_res  = 1'b1;
							ctrl.res_code = pfa_pkg::RES_BAD;
							state_n       = pfa_pkg::ST_RESP;
						end
					end
					pfa_pkg::CMD_MARK: begin
						if (stat.f_in_store) begin
							ctrl.row_rd  = 1'b1;
							ctrl.row_src = pfa_pkg::ROW_FRAME;
							state_n      = pfa_pkg::ST_UPD_ROW;
						end else begin
							ctrl.set_res  = 1'b1;
							ctrl.res_code = pfa_pkg::RES_BAD;
							state_n       = pfa_pkg::ST_RESP;
						end
					end
					default: begin
						ctrl.set_res  = 1'b1;
						ctrl.res_code = pfa_pkg::RES_BAD;
						state_n       = pfa_pkg::ST_RESP;
					end
				endcase
			end
			pfa_pkg::ST_A_ROW0: begin
				if (stat.row_hit) begin
					ctrl.row_wr  = 1'b1;
					ctrl.sum_rd  = 1'b1;
					ctrl.sum_src = pfa_pkg::SUM_ROW;
					state_n      = pfa_pkg::ST_SUM_WR;
				end else begin
					ctrl.sum_rd  = 1'b1;
					ctrl.sum_src = pfa_pkg::SUM_START;
					state_n      = pfa_pkg::ST_A_SCAN;
				end
			end
			pfa_pkg::ST_A_SCAN: begin
				priority if (stat.scan_hit) begin
					ctrl.row_rd  = 1'b1;
					ctrl.row_src = pfa_pkg::ROW_SCAN;
					state_n      = pfa_pkg::ST_A_ROW;
				end else if (stat.scan_last) begin
					ctrl.set_res  = 1'b1;
					ctrl.res_code = pfa_pkg::RES_EMPTY;
					state_n       = pfa_pkg::ST_RESP;
				end else begin
					ctrl.sum_rd  = 1'b1;
					ctrl.sum_src = pfa_pkg::SUM_NEXT;
				end
			end
			pfa_pkg::ST_A_ROW: begin
				if (stat.row_hit) begin
					ctrl.row_wr  = 1'b1;
					ctrl.sum_rd  = 1'b1;
					ctrl.sum_src = pfa_pkg::SUM_ROW;
					state_n      = pfa_pkg::ST_SUM_WR;
				end else begin
					// free frame beyond the window end
					ctrl.set_res  = 1'b1;
					ctrl.res_code = pfa_pkg::RES_EMPTY;
					state_n       = pfa_pkg::ST_RESP;
				end
			end
			pfa_pkg::ST_UPD_ROW: begin
				if (stat.cmd == pfa_pkg::CMD_FREE && !stat.f_used) begin
					ctrl.set_res  = 1'b1;
					ctrl.res_code = pfa_pkg::RES_BAD;
					state_n       = pfa_pkg::ST_RESP;
				end else begin
					ctrl.row_wr  = 1'b1;
					ctrl.sum_rd  = 1'b1;
					ctrl.sum_src = pfa_pkg::SUM_ROW;
					state_n      = pfa_pkg::ST_SUM_WR;
				end
			end
			pfa_pkg::ST_SUM_WR: begin
				ctrl.sum_wr   = 1'b1;
				ctrl.set_res  = 1'b1;
				ctrl.res_code = pfa_pkg::RES_OK;
				state_n       = pfa_pkg::ST_RESP;
			end
			pfa_pkg::ST_RESP: begin
				if (out_free) begin
					ctrl.load_out = 1'b1;
					state_n       = pfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = pfa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/pfa_dp.sv =====
`default_nettype none

module pfa_dp #(
	parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]      cfg_data,
	input  logic [pfa_pkg::CMD_W-1:0]      cmd,
	input  logic [pfa_pkg::FRAME_W-1:0]    frame_index,
	output logic [pfa_pkg::FRAME_W-1:0]    granted_frame,
	output logic [pfa_pkg::STATUS_W-1:0]   status,
	input  pfa_pkg::ctrl_t                 ctrl,
	output pfa_pkg::stat_t                 stat
);

	localparam int LG    = pfa_pkg::ROW_LOG;
	localparam int RF    = pfa_pkg::ROW_FRAMES;
	localparam int RB    = pfa_pkg::ROW_BITS;
	localparam int FW    = $clog2(NUM_FRAMES);
	localparam int RW    = FW - LG;
	localparam int ROWS  = (NUM_FRAMES + RF - 1) / RF;
	localparam int SROWS = (ROWS + RF - 1) / RF;
	localparam int SW    = (RW > LG) ? RW - LG : 1;
	localparam int RXW   = SW + LG;
	localparam int EW    = (FW + 1 > pfa_pkg::CFG_W) ? FW + 1 : pfa_pkg::CFG_W;
	localparam int RDW   = EW - LG;
	localparam int GXW   = FW + pfa_pkg::FRAME_W;

	function automatic logic [LG-1:0] lowest_set(input logic [RF-1:0] v);
		logic [LG-1:0] k;
		k = '0;
		for (int i = RF - 1; i >= 0; i--) begin
			if (v[i]) begin
				k = LG'(i);
			end
		end
		return k;
	endfunction

	logic [pfa_pkg::CFG_W-1:0]    first_q;
	logic [pfa_pkg::CFG_W-1:0]    limit_q;
	logic [pfa_pkg::CMD_W-1:0]    cmd_q;
	logic [pfa_pkg::FRAME_W-1:0]  f_q;
	logic [RW-1:0]                clr_cnt_q;
	logic [RW-1:0]                row_q;
	logic [SW-1:0]                s_q;
	logic                         first_scan_q;
	logic [FW-1:0]                hit_frame_q;
	logic                         newfree_q;
	logic [FW-1:0]                res_gr_q;
	logic [pfa_pkg::STATUS_W-1:0] res_code_q;
	logic [pfa_pkg::FRAME_W-1:0]  out_gr_q;
	logic [pfa_pkg::STATUS_W-1:0] out_status_q;

	logic [EW-1:0]    first_e;
	logic [EW-1:0]    limit_e;
	logic [EW-1:0]    end_e;
	logic [EW-1:0]    fe;
	logic [RW-1:0]    r0;
	logic [RXW-1:0]   r0x;
	logic [RW-1:0]    f_row;
	logic [RB-1:0]    rd_row;
	logic [RB-1:0]    new_row;
	logic [RF-1:0]    free_v;
	logic [RF-1:0]    win_mask;
	logic [RF-1:0]    hit_v;
	logic [LG-1:0]    hit_k;
	logic [LG-1:0]    pos;
	logic [1:0]       new_code;
	logic             newfree_n;
	logic [RF-1:0]    sum_rd_data;
	logic [RF-1:0]    scan_v;
	logic [LG-1:0]    scan_k;
	logic [RXW-1:0]   scan_rx;
	logic [RW-1:0]    scan_row;
	logic [RXW-1:0]   rowx;
	logic [SW-1:0]    srow_cur;
	logic [RF-1:0]    new_sum;
	logic [RF-1:0]    clr_pat;
	logic             clr_in_sum;
	logic [RW-1:0]    row_ra;
	logic [SW-1:0]    sum_ra;
	logic             row_we;
	logic [RW-1:0]    row_wa;
	logic [RB-1:0]    row_wd;
	logic             sum_we;
	logic [SW-1:0]    sum_wa;
	logic [RF-1:0]    sum_wd;
	logic [GXW-1:0]   gx;

	// Config registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			limit_q <= pfa_pkg::FRAME_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pfa_pkg::CFG_FIRST_USABLE: first_q <= cfg_data;
				pfa_pkg::CFG_FRAME_LIMIT:  limit_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctrl.clr_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			cmd_q <= cmd;
			f_q   <= frame_index;
		end
		if (ctrl.row_rd) begin
			row_q <= row_ra;
		end
		if (ctrl.sum_rd) begin
			s_q          <= sum_ra;
			first_scan_q <= (ctrl.sum_src == pfa_pkg::SUM_START);
		end
		if (ctrl.row_wr) begin
			newfree_q   <= newfree_n;
			hit_frame_q <= {row_q, hit_k};
		end
		if (ctrl.set_res) begin
			res_code_q <= ctrl.res_code;
			res_gr_q   <= (ctrl.res_code == pfa_pkg::RES_OK && cmd_q == pfa_pkg::CMD_ALLOC)
				? hit_frame_q : '0;
		end
		if (ctrl.load_out) begin
			out_status_q <= res_code_q;
			out_gr_q     <= gx[pfa_pkg::FRAME_W-1:0];
		end
	end

	assign gx            = GXW'(res_gr_q);
	assign granted_frame = out_gr_q;
	assign status        = out_status_q;

	// Window bounds; a limit past the store clamps to the store size.
	assign first_e = EW'(first_q);
	assign limit_e = EW'(limit_q);
	assign end_e   = (limit_e > EW'(NUM_FRAMES)) ? EW'(NUM_FRAMES) : limit_e;
	assign fe      = EW'(f_q);
	assign r0      = first_e[FW-1:LG];
	assign r0x     = RXW'(r0);
	assign f_row   = fe[FW-1:LG];

	// Row evaluation: window mask, lowest free frame, updated row.
	always_comb begin
		logic [RDW-1:0] rq;
		logic [RDW-1:0] fr;
		logic [RDW-1:0] er;
		logic           row_above;
		logic           row_at_lo;
		logic           row_below;
		logic           row_at_hi;
		rq        = RDW'(row_q);
		fr        = first_e[EW-1:LG];
		er        = end_e[EW-1:LG];
		row_above = rq > fr;
		row_at_lo = rq == fr;
		row_below = rq < er;
		row_at_hi = rq == er;
		for (int k = 0; k < RF; k++) begin
			free_v[k]   = rd_row[2*k +: 2] == pfa_pkg::FS_FREE;
			win_mask[k] = (row_above || (row_at_lo && LG'(k) >= first_e[LG-1:0])) &&
				(row_below || (row_at_hi && LG'(k) < end_e[LG-1:0]));
		end
		hit_v = free_v & win_mask;
		hit_k = lowest_set(hit_v);

		pos = (cmd_q == pfa_pkg::CMD_ALLOC) ? hit_k : f_q[LG-1:0];
		priority if (cmd_q == pfa_pkg::CMD_ALLOC) begin
			new_code = pfa_pkg::FS_USED;
		end else if (cmd_q == pfa_pkg::CMD_FREE) begin
			new_code = pfa_pkg::FS_FREE;
		end else begin
			new_code = pfa_pkg::FS_HOLE;
		end
		new_row = rd_row;
		new_row[{pos, 1'b0} +: 2] = new_code;
		newfree_n = 1'b0;
		for (int k = 0; k < RF; k++) begin
			if (new_row[2*k +: 2] == pfa_pkg::FS_FREE) begin
				newfree_n = 1'b1;
			end
		end
	end

	// Summary: one bit per row, set while the row holds a free frame.
	always_comb begin
		logic [RF-1:0] above;
		for (int b = 0; b < RF; b++) begin
			above[b]   = LG'(b) > r0x[LG-1:0];
			clr_pat[b] = (RXW + 1)'({clr_cnt_q[SW-1:0], LG'(b)}) < (RXW + 1)'(ROWS);
		end
		scan_v   = sum_rd_data & (first_scan_q ? above : '1);
		scan_k   = lowest_set(scan_v);
		scan_rx  = {s_q, scan_k};
		scan_row = scan_rx[RW-1:0];
		rowx     = RXW'(row_q);
		srow_cur = rowx[RXW-1:LG];
		new_sum  = sum_rd_data;
		new_sum[rowx[LG-1:0]] = newfree_q;
	end

	assign clr_in_sum = (RW + 1)'(clr_cnt_q) < (RW + 1)'(SROWS);

	always_comb begin
		unique case (ctrl.row_src)
			pfa_pkg::ROW_FRAME: row_ra = f_row;
			pfa_pkg::ROW_SCAN:  row_ra = scan_row;
			default:            row_ra = r0;
		endcase
		unique case (ctrl.sum_src)
			pfa_pkg::SUM_NEXT: sum_ra = s_q + 1'b1;
			pfa_pkg::SUM_ROW:  sum_ra = srow_cur;
			default:           sum_ra = r0x[RXW-1:LG];
		endcase
	end

	assign row_we = ctrl.clr_en || ctrl.row_wr;
	assign row_wa = ctrl.clr_en ? clr_cnt_q : row_q;
	assign row_wd = ctrl.clr_en ? '0 : new_row;
	assign sum_we = (ctrl.clr_en && clr_in_sum) || ctrl.sum_wr;
	assign sum_wa = ctrl.clr_en ? clr_cnt_q[SW-1:0] : srow_cur;
	assign sum_wd = ctrl.clr_en ? clr_pat : new_sum;

	pfa_ram #(
		.WIDTH  (RB),
		.DEPTH  (ROWS),
		.ADDR_W (RW)
	) u_status_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_wa),
		.wdata (row_wd),
		.re    (ctrl.row_rd),
		.raddr (row_ra),
		.rdata (rd_row)
	);

	pfa_ram #(
		.WIDTH  (RF),
		.DEPTH  (SROWS),
		.ADDR_W (SW)
	) u_summary_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_wa),
		.wdata (sum_wd),
		.re    (ctrl.sum_rd),
		.raddr (sum_ra),
		.rdata (sum_rd_data)
	);

	assign stat.clr_done   = clr_cnt_q == RW'(ROWS - 1);
	assign stat.cmd        = cmd_q;
	assign stat.win_empty  = first_e >= end_e;
	assign stat.f_in_win   = (fe >= first_e) && (fe < end_e);
	assign stat.f_in_store = fe < EW'(NUM_FRAMES);
	assign stat.row_hit    = |hit_v;
	assign stat.f_used     = rd_row[{f_q[LG-1:0], 1'b0} +: 2] == pfa_pkg::FS_USED;
	assign stat.scan_hit   = |scan_v;
	assign stat.scan_last  = s_q == SW'(SROWS - 1);

endmodule

`default_nettype wire

// ===== design/page_frame_allocator_unit.sv =====
// A command rejected on opcode or range, or an allocate on an empty window, is answered
// without a RAM access; a free of a frame not in use reads its row but writes nothing.
// Allocate walks the summary words (NUM_FRAMES/1024, rounded up) only when the window's
// first row holds no free frame in the window. One command at a time: the next input beat
// is taken in the cycle after the result is loaded.
// Reset: async, active low; in_ready stays low during the clearing pass over both RAMs.
`default_nettype none

module page_frame_allocator_unit #(
	parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// Configuration write port: index 0 first usable frame, index 1 frame limit.
	input  logic                           cfg_wr_en,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]      cfg_data,

	// Command channel.
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pfa_pkg::CMD_W-1:0]      cmd,
	input  logic [pfa_pkg::FRAME_W-1:0]    frame_index,

	// Result channel.
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pfa_pkg::FRAME_W-1:0]    granted_frame,
	output logic [pfa_pkg::STATUS_W-1:0]   status
);

	// The frame store lives in two RAMs inside the datapath:
	//   status RAM  - one 64-bit row per 32 frames, 2 bits per frame
	//                 (free, used, hole).
	//   summary RAM - one bit per status row, set while that row holds
	//                 at least one free frame; 32 rows per word.
	// Allocate reads the row of the first usable frame and takes the
	// lowest free frame in the window there. On a miss, walk the summary
	// words from that row upward, one word a cycle, read the first row
	// flagged free and check the hit against the window end. Every command's row
	// write is followed by a read-modify-write of its summary bit.
	// Free and mark do one row read-modify-write and the summary update.

	pfa_pkg::ctrl_t ctrl;
	pfa_pkg::stat_t stat;

	// Controller: sequences the clearing pass, the command flow and the
	// result beat; the result register holds a finished beat while the
	// sink stalls.
	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// Datapath: config registers, window checks, RAMs, find-first-free
	// and the result payload registers.
	pfa_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.frame_index   (frame_index),
		.granted_frame (granted_frame),
		.status        (status),
		.ctrl          (ctrl),
		.stat          (stat)
	);

endmodule

`default_nettype wire
